// ===== rtl/core/fqps_pkg.sv =====
// Shared types and constants for the fair-queuing PIFO scheduler.
// No dependencies.
package fqps_pkg;

    localparam int StatusW = 3;
    localparam logic [2:0] ST_QUEUED = 3'd0;
    localparam logic [2:0] ST_BURST  = 3'd1;
    localparam logic [2:0] ST_QFULL  = 3'd2;
    localparam logic [2:0] ST_TFULL  = 3'd3;
    localparam logic [2:0] ST_DEQ    = 3'd4;
    localparam logic [2:0] ST_EMPTY  = 3'd5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic CFG_WEIGHT = 1'b0;
    localparam logic CFG_BURST  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] packet_handle;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_handle;
        logic [31:0] finish_round;
        logic [6:0]  queue_count;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item
        logic lookup;   // register flow lookup and start round
        logic decide;   // compute finish round, status
        logic commit;   // update state, build result
    } dp_cmd_t;

endpackage

// ===== rtl/core/fair_queue_pifo_scheduler_unit.sv =====
// Fair-queuing PIFO scheduler, top level.
// One item at a time: the item is loaded in idle on the input transfer, then the
// controller steps through its lookup, decide and commit states, raises the
// registered result valid and holds the result until it transfers; the next
// input is taken the cycle after the result transfers.
// Reset (rst_n, async low) empties the queue and flow table, round and
// sequence to zero, weight 2, burst limit 100.
module fair_queue_pifo_scheduler_unit #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int FLOW_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fqps_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output fqps_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);
    import fqps_pkg::*;

    dp_cmd_t cmd;

    fqps_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
    );

    fqps_dp #(.QUEUE_DEPTH(QUEUE_DEPTH), .FLOW_ENTRIES(FLOW_ENTRIES)) u_dp (
        .clk, .rst_n, .cmd, .in_item(in_data), .cfg_we, .cfg_index, .cfg_data,
        .out_item(out_data)
    );

endmodule

// ===== rtl/core/fqps_ctrl.sv =====
// Controller state machine for the scheduler: sequences load, lookup,
// decide and commit, and holds the result until transfer. Uses fqps_pkg.
module fqps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output fqps_pkg::dp_cmd_t cmd
);
    import fqps_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LOOK, S_DEC, S_COMMIT, S_OUT} state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        cmd.lookup = (state_reg == S_LOOK);
        cmd.decide = (state_reg == S_DEC);
        cmd.commit = (state_reg == S_COMMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:   if (in_valid) state_reg <= S_LOOK;
                S_LOOK:   state_reg <= S_DEC;
                S_DEC:    state_reg <= S_COMMIT;
                S_COMMIT:
                begin
                    state_reg     <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/fqps_dp.sv =====
// Datapath: flow table, sorted shift-register PIFO, round state and
// result register. Uses fqps_pkg; driven by fqps_ctrl commands.
module fqps_dp #(
    parameter int QUEUE_DEPTH  = 64,
    parameter int FLOW_ENTRIES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fqps_pkg::dp_cmd_t    cmd,
    input  fqps_pkg::in_item_t   in_item,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    output fqps_pkg::out_item_t  out_item
);
    import fqps_pkg::*;

    localparam int FW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [15:0] weight_reg, burst_reg;
    in_item_t    item_reg;

    logic [FLOW_ENTRIES-1:0] fvalid_reg;
    logic [31:0] fsrc_reg  [FLOW_ENTRIES];
    logic [31:0] fdst_reg  [FLOW_ENTRIES];
    logic [31:0] flast_reg [FLOW_ENTRIES];

    logic [31:0] efin_reg [QUEUE_DEPTH];
    logic [15:0] ehdl_reg [QUEUE_DEPTH];
    logic [CW-1:0] count_reg;
    logic [31:0] round_reg, seq_reg;

    // lookup stage results
    logic          hit_reg, free_ok_reg;
    logic [FW-1:0] slot_reg;
    logic [31:0]   start_reg;
    // decide stage results
    logic [31:0]   fin_reg;
    logic [2:0]    st_reg;
    out_item_t     out_reg;

    assign out_item = out_reg;

    // Flow match and lowest free slot.
    logic [FLOW_ENTRIES-1:0] match;
    logic          any_hit, any_free;
    logic [FW-1:0] hit_idx, free_idx;
    always_comb
    begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < FLOW_ENTRIES; i++)
        begin
            match[i] = fvalid_reg[i] && fsrc_reg[i] == item_reg.src_addr
                       && fdst_reg[i] == item_reg.dst_addr;
            if (match[i])
            begin
                any_hit = 1'b1;
                hit_idx = FW'(i);
            end
        end
        for (int i = FLOW_ENTRIES - 1; i >= 0; i--)
        begin
            if (!fvalid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = FW'(i);
            end
        end
    end

    logic [31:0] last_rd;
    assign last_rd = any_hit ? flast_reg[hit_idx] : 32'd0;

    logic [32:0] sum;
    logic [31:0] fin_c, diff;
    assign sum   = {1'b0, start_reg} + {17'd0, weight_reg};
    assign fin_c = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign diff  = fin_c - round_reg;

    // Insert position: first entry with finish greater than the new one.
    logic [QUEUE_DEPTH-1:0] gt;
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            gt[i] = (CW'(i) < count_reg) && (efin_reg[i] > fin_reg);
    end

    logic do_ins, do_pop;
    assign do_ins = cmd.commit && item_reg.op == OP_ENQ && st_reg == ST_QUEUED;
    assign do_pop = cmd.commit && item_reg.op == OP_DEQ && st_reg == ST_DEQ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= 16'd2;
            burst_reg  <= 16'd100;
            fvalid_reg <= '0;
            count_reg  <= '0;
            round_reg  <= '0;
            seq_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WEIGHT) weight_reg <= cfg_data;
                else                         burst_reg  <= cfg_data;
            end
            // Create the flow at lookup even if the packet drops later.
            if (cmd.lookup && item_reg.op == OP_ENQ && !any_hit && any_free)
                fvalid_reg[free_idx] <= 1'b1;
            if (do_ins)
            begin
                count_reg <= count_reg + 1'b1;
                seq_reg   <= seq_reg + 32'd1;
            end
            if (do_pop)
            begin
                count_reg <= count_reg - 1'b1;
                round_reg <= efin_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.lookup)
        begin
            hit_reg     <= any_hit;
            free_ok_reg <= any_free;
            slot_reg    <= any_hit ? hit_idx : free_idx;
            start_reg   <= (last_rd > round_reg) ? last_rd : round_reg;
            if (item_reg.op == OP_ENQ && !any_hit && any_free)
            begin
                fsrc_reg[free_idx]  <= item_reg.src_addr;
                fdst_reg[free_idx]  <= item_reg.dst_addr;
                flast_reg[free_idx] <= 32'd0;
            end
        end
        if (cmd.decide)
        begin
            fin_reg <= fin_c;
            if (item_reg.op == OP_DEQ)
                st_reg <= (count_reg == '0) ? ST_EMPTY : ST_DEQ;
            else if (!hit_reg && !free_ok_reg)
                st_reg <= ST_TFULL;
            else if (diff >= {16'd0, burst_reg})
                st_reg <= ST_BURST;
            else if (count_reg >= CW'(QUEUE_DEPTH))
                st_reg <= ST_QFULL;
            else
                st_reg <= ST_QUEUED;
        end
        if (do_ins)
        begin
            flast_reg[slot_reg] <= fin_reg;
            // Shift entries at or after the insert point down one place.
            for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
            begin
                if (gt[i])
                begin
                    if (i + 1 < QUEUE_DEPTH)
                    begin
                        efin_reg[(i + 1) % QUEUE_DEPTH] <= efin_reg[i];
                        ehdl_reg[(i + 1) % QUEUE_DEPTH] <= ehdl_reg[i];
                    end
                    if (i == 0 || !gt[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH])
                    begin
                        efin_reg[i] <= fin_reg;
                        ehdl_reg[i] <= item_reg.packet_handle;
                    end
                end
                else if (CW'(i) == count_reg && (i == 0 ||
                         !gt[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH]))
                begin
                    efin_reg[i] <= fin_reg;
                    ehdl_reg[i] <= item_reg.packet_handle;
                end
            end
        end
        if (do_pop)
        begin
            for (int i = 0; i + 1 < QUEUE_DEPTH; i++)
            begin
                efin_reg[i] <= efin_reg[i + 1];
                ehdl_reg[i] <= ehdl_reg[i + 1];
            end
        end
        if (cmd.commit)
        begin
            out_reg.status     <= st_reg;
            out_reg.out_handle <= (st_reg == ST_DEQ) ? ehdl_reg[0] : 16'd0;
            case (st_reg) inside
                ST_DEQ:                       out_reg.finish_round <= efin_reg[0];
                ST_QUEUED, ST_BURST, ST_QFULL: out_reg.finish_round <= fin_reg;
                default:                      out_reg.finish_round <= 32'd0;
            endcase
            if (do_ins)      out_reg.queue_count <= 7'(count_reg + 1'b1);
            else if (do_pop) out_reg.queue_count <= 7'(count_reg - 1'b1);
            else             out_reg.queue_count <= 7'(count_reg);
        end
    end

endmodule

// ===== rtl/core/fqps_checker.sv =====
// Port-level checker for the scheduler top level, with its bind.
// Uses fqps_pkg.
module fqps_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input fqps_pkg::out_item_t out_data
);
    import fqps_pkg::*;

    // No new input while a result waits.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken with result pending");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result changed while stalled");

    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_DEQ |-> out_data.out_handle == 16'd0)
        else $error("handle nonzero without dequeue");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##4 out_valid)
        else $error("result missing after transfer");

endmodule

bind fair_queue_pifo_scheduler_unit fqps_checker u_fqps_checker (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
